// ===== rtl/brf_pkg.sv =====
// brf_pkg: shared types, mode codes, masks and slot decode for the banked register file
// no dependencies; imported by every rtl module of the block

package brf_pkg;

   typedef enum logic [2:0] {
      OP_READ         = 3'd0,
      OP_USER_READ    = 3'd1,
      OP_WRITE        = 3'd2,
      OP_USER_WRITE   = 3'd3,
      OP_STATUS_READ  = 3'd4,
      OP_STATUS_WRITE = 3'd5,
      OP_SAVED_READ   = 3'd6,
      OP_SAVED_WRITE  = 3'd7
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [3:0]  reg_index;
      logic [31:0] write_value;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [4:0]  cur_mode;
      logic        mode_has_saved;
      logic        is_privileged;
   } rsp_item_type;

   // write controls handed to the status unit
   typedef struct packed {
      logic        we_status;
      logic        we_saved;
      logic [31:0] value;
   } psr_ctl_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] slot;
   } slot_sel_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] idx;
   } saved_sel_type;

   localparam int unsigned NUM_SLOTS = 31;
   localparam int unsigned NUM_SAVED = 5;

   localparam logic [31:0] MODE_MASK  = 32'h0000_001F;
   localparam logic [31:0] USER_WMASK = 32'hF80F_0200;
   localparam logic [31:0] PRIV_WMASK = 32'hF90F_03FF;
   localparam logic [31:0] RESET_STATUS = 32'h0000_0013;

   localparam logic [4:0] M_USR = 5'h10;
   localparam logic [4:0] M_FIQ = 5'h11;
   localparam logic [4:0] M_IRQ = 5'h12;
   localparam logic [4:0] M_SVC = 5'h13;
   localparam logic [4:0] M_ABT = 5'h17;
   localparam logic [4:0] M_UND = 5'h1B;
   localparam logic [4:0] M_SYS = 5'h1F;

   localparam logic [4:0] SLOT_R13_BASE = 5'd18;
   localparam logic [4:0] SLOT_R14_BASE = 5'd24;
   localparam logic [4:0] SLOT_R15      = 5'd30;
   localparam logic [4:0] FIQ_OFFSET    = 5'd5;

   // r13/r14 bank per mode: user/sys, svc, abt, und, irq, fiq
   function automatic saved_sel_type mode_bank(input logic [4:0] m);
      saved_sel_type r;
      r.hit = 1'b1;
      case (m)
         M_USR, M_SYS: r.idx = 3'd0;
         M_SVC:        r.idx = 3'd1;
         M_ABT:        r.idx = 3'd2;
         M_UND:        r.idx = 3'd3;
         M_IRQ:        r.idx = 3'd4;
         M_FIQ:        r.idx = 3'd5;
         default: begin
            r.hit = 1'b0;
            r.idx = 3'd0;
         end
      endcase
      return r;
   endfunction

   function automatic saved_sel_type saved_slot(input logic [4:0] m);
      saved_sel_type r;
      r.hit = 1'b1;
      case (m)
         M_SVC:   r.idx = 3'd0;
         M_ABT:   r.idx = 3'd1;
         M_UND:   r.idx = 3'd2;
         M_IRQ:   r.idx = 3'd3;
         M_FIQ:   r.idx = 3'd4;
         default: begin
            r.hit = 1'b0;
            r.idx = 3'd0;
         end
      endcase
      return r;
   endfunction

   function automatic slot_sel_type reg_slot(input logic [3:0] rg, input logic user_view,
                                             input logic [4:0] m);
      slot_sel_type  r;
      saved_sel_type b;
      b = mode_bank(m);
      r.hit = 1'b1;
      if (rg < 4'd8) begin
         r.slot = {1'b0, rg};
      end else if (rg == 4'd15) begin
         r.slot = SLOT_R15;
      end else if (rg <= 4'd12) begin
         r.slot = {1'b0, rg} + ((!user_view && m == M_FIQ) ? FIQ_OFFSET : 5'd0);
      end else begin
         if (user_view) begin
            b.hit = 1'b1;
            b.idx = 3'd0;
         end
         r.hit  = b.hit;
         r.slot = ((rg == 4'd13) ? SLOT_R13_BASE : SLOT_R14_BASE) + {2'b00, b.idx};
      end
      return r;
   endfunction

endpackage

// ===== rtl/brf_regs.sv =====
// brf_regs: the 31 general register slots, one write and one read port
// depends on brf_pkg for the slot count

module brf_regs
   import brf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [4:0]  wr_slot,
   input  logic [31:0] wr_data,
   input  logic [4:0]  rd_slot,
   output logic [31:0] rd_data
);

   logic [31:0] slot_ff [NUM_SLOTS];

   assign rd_data = slot_ff[rd_slot];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) slot_ff[i] <= '0;
      end else if (wr_en) begin
         slot_ff[wr_slot] <= wr_data;
      end
   end

endmodule

// ===== rtl/brf_psr.sv =====
// brf_psr: status word and the five saved status words, masked writes and saved reads
// depends on brf_pkg for masks, mode codes and the control struct

module brf_psr
   import brf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  psr_ctl_type ctl,
   output logic [31:0] status_word,
   output logic [31:0] status_next,
   output logic [31:0] saved_rd
);

   logic [31:0]   status_ff, status_in;
   logic [31:0]   saved_ff [NUM_SAVED];
   logic [4:0]    mode;
   logic [31:0]   wmask;
   saved_sel_type sel;

   assign mode  = status_ff[4:0];
   assign wmask = (mode == M_USR) ? USER_WMASK : PRIV_WMASK;
   assign sel   = saved_slot(mode);

   always_comb begin
      status_in = status_ff;
      if (ctl.we_status) status_in = (status_ff & ~wmask) | (ctl.value & wmask);
   end

   // user and system have no saved copy and read the live word
   always_comb begin
      if (mode == M_USR || mode == M_SYS) saved_rd = status_ff;
      else if (sel.hit)                   saved_rd = saved_ff[sel.idx];
      else                                saved_rd = '0;
   end

   assign status_word = status_ff;
   assign status_next = status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= RESET_STATUS;
         for (int i = 0; i < NUM_SAVED; i++) saved_ff[i] <= '0;
      end else begin
         status_ff <= status_in;
         if (ctl.we_saved && sel.hit) saved_ff[sel.idx] <= ctl.value;
      end
   end

endmodule

// ===== rtl/banked_register_file_modes.sv =====
// banked_register_file_modes: top level, input register, access logic and result register
// depends on brf_pkg, brf_regs and brf_psr
//
//   channel | ports                          | direction | payload
//   request | req_valid req_stall req_item   | in        | opcode, reg_index, write_value
//   result  | rsp_valid rsp_stall rsp_item   | out       | read_data, cur_mode, flags
//
// one item per cycle sustained while rsp_stall is low; an item goes from acceptance to result via
// the input register, then the access logic into the result register
// state is updated as an item moves from the input register into the result register,
// so the next item always sees the previous one's writes
// reset clears all register slots and saved words and sets the status word to supervisor
// a stalled result holds its register; the input register then holds and req_stall rises

module banked_register_file_modes
   import brf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;

   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic out_take;   // result register can load this cycle
   logic fire;       // item in input register is processed now

   assign out_take  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_take;
   assign req_stall = in_valid_ff && !out_take;

   // access decode
   logic [4:0]   mode;
   logic [31:0]  status_word, status_next, saved_rd, reg_rd;
   slot_sel_type sel;
   logic         user_view, is_reg_read, is_reg_write;
   psr_ctl_type  psr_ctl;
   logic [4:0]   new_mode;

   assign mode         = status_word[4:0];
   assign user_view    = (in_item_ff.opcode == OP_USER_READ) ||
                         (in_item_ff.opcode == OP_USER_WRITE);
   assign sel          = reg_slot(in_item_ff.reg_index, user_view, mode);
   assign is_reg_read  = (in_item_ff.opcode == OP_READ) || (in_item_ff.opcode == OP_USER_READ);
   assign is_reg_write = (in_item_ff.opcode == OP_WRITE) ||
                         (in_item_ff.opcode == OP_USER_WRITE);

   assign psr_ctl.we_status = fire && (in_item_ff.opcode == OP_STATUS_WRITE);
   assign psr_ctl.we_saved  = fire && (in_item_ff.opcode == OP_SAVED_WRITE);
   assign psr_ctl.value     = in_item_ff.write_value;

   brf_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fire && is_reg_write && sel.hit),
      .wr_slot (sel.slot),
      .wr_data (in_item_ff.write_value),
      .rd_slot (sel.slot),
      .rd_data (reg_rd)
   );

   brf_psr u_psr (
      .clock       (clock),
      .reset       (reset),
      .ctl         (psr_ctl),
      .status_word (status_word),
      .status_next (status_next),
      .saved_rd    (saved_rd)
   );

   // result fields; mode reflects a status write done by this same item
   assign new_mode = status_next[4:0];

   always_comb begin
      out_item_in.read_data = '0;
      case (in_item_ff.opcode)
         OP_READ, OP_USER_READ: begin
            if (sel.hit) out_item_in.read_data = reg_rd;
         end
         OP_STATUS_READ: out_item_in.read_data = status_word;
         OP_SAVED_READ:  out_item_in.read_data = saved_rd;
         default:        out_item_in.read_data = '0;
      endcase
      if (!is_reg_read && is_reg_write) out_item_in.read_data = '0;
      out_item_in.cur_mode       = new_mode;
      out_item_in.mode_has_saved = !(new_mode == M_USR || new_mode == M_SYS);
      out_item_in.is_privileged  = (new_mode != M_USR);
   end

   // handshake state
   always_comb begin
      in_valid_in = in_valid_ff;
      if (fire)       in_valid_in = 1'b0;
      if (!req_stall) in_valid_in = req_valid;
      out_valid_in = out_valid_ff;
      if (out_take) out_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) in_item_ff <= req_item;
      if (fire)                    out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ===== sim/banked_register_file_modes_tb.sv =====
// banked_register_file_modes_tb: self-checking bench for the mode-banked register file
// drives accesses through req_/rsp_ channels, predicts every result in place and compares
// depends on brf_pkg and the banked_register_file_modes rtl, nothing else

module banked_register_file_modes_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import brf_pkg::*;

   localparam int ITEM_COUNT   = 1250;    // random accesses after the directed ones
   localparam int USER_ENTRY   = 1100;    // random access that drops into user mode for good
   localparam int HOLD_AFTER   = 300;     // accepted items before the long receiver hold
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 20;      // plenty of margin for the input and result registers
   localparam int CYCLE_LIMIT  = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   banked_register_file_modes dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   // sync reset, held once at the start
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------------
   // predictor state: shadow copy of the register slots, status word and saved words
   // slot map: 0..7 r0..r7, 8..12 user r8..r12, 13..17 fiq r8..r12,
   // r13 and r14 banks from SLOT_R13_BASE / SLOT_R14_BASE, r15 at SLOT_R15
   // ---------------------------------------------------------------------------
   logic [31:0] reg_copies [NUM_SLOTS];
   logic [31:0] spsr [NUM_SAVED];
   logic [31:0] cpsr;

   req_item_type access_q[$];         // accesses still to be offered
   rsp_item_type predicted_rsp[$];    // results owed by the block, oldest first

   int items_queued   = 0;
   int items_accepted = 0;
   int fail_count     = 0;

   // storage slot of an architectural register, -1 when the mode has no copy
   function automatic int storage_slot(input logic [3:0] rg, input logic user_view,
                                       input logic [4:0] m);
      int bank;
      if (rg < 4'd8) return int'(rg);
      if (rg == 4'd15) return int'(SLOT_R15);
      // r8..r12 only have a second copy in fiq mode
      if (rg <= 4'd12) return int'(rg) + ((!user_view && m == M_FIQ) ? int'(FIQ_OFFSET) : 0);
      if (user_view) bank = 0;
      else begin
         case (m)
            M_USR, M_SYS: bank = 0;   // system shares the user r13/r14
            M_SVC:        bank = 1;
            M_ABT:        bank = 2;
            M_UND:        bank = 3;
            M_IRQ:        bank = 4;
            M_FIQ:        bank = 5;
            default:      return -1;  // invalid mode: no r13/r14 at all
         endcase
      end
      return ((rg == 4'd13) ? int'(SLOT_R13_BASE) : int'(SLOT_R14_BASE)) + bank;
   endfunction

   // saved-status word of a mode, -1 for user, system and invalid modes
   function automatic int saved_index(input logic [4:0] m);
      case (m)
         M_SVC:   return 0;
         M_ABT:   return 1;
         M_UND:   return 2;
         M_IRQ:   return 3;
         M_FIQ:   return 4;
         default: return -1;
      endcase
   endfunction

   // performs one access on the shadow state and returns the result it must produce
   function automatic rsp_item_type apply_access(input req_item_type it);
      rsp_item_type r;
      logic [4:0]   m;
      logic [31:0]  wmask;
      int           s;
      r = '0;
      m = cpsr[4:0];
      case (it.opcode)
         OP_READ, OP_USER_READ: begin
            s = storage_slot(it.reg_index, it.opcode == OP_USER_READ, m);
            if (s >= 0) r.read_data = reg_copies[s];
         end
         OP_WRITE, OP_USER_WRITE: begin
            s = storage_slot(it.reg_index, it.opcode == OP_USER_WRITE, m);
            if (s >= 0) reg_copies[s] = it.write_value;
         end
         OP_STATUS_READ: r.read_data = cpsr;
         OP_STATUS_WRITE: begin
            // bits outside the mask keep their old value; user mode cannot touch the mode field
            wmask = (m == M_USR) ? USER_WMASK : PRIV_WMASK;
            cpsr  = (cpsr & ~wmask) | (it.write_value & wmask);
         end
         OP_SAVED_READ: begin
            // user and system read back the live status word
            if (m == M_USR || m == M_SYS) r.read_data = cpsr;
            else begin
               s = saved_index(m);
               if (s >= 0) r.read_data = spsr[s];
            end
         end
         OP_SAVED_WRITE: begin
            s = saved_index(m);
            if (s >= 0) spsr[s] = it.write_value;
         end
      endcase
      // attributes reflect the mode after the access; invalid modes count as privileged
      r.cur_mode       = cpsr[4:0];
      r.mode_has_saved = !(cpsr[4:0] == M_USR || cpsr[4:0] == M_SYS);
      r.is_privileged  = (cpsr[4:0] != M_USR);
      return r;
   endfunction

   task automatic queue_access(input opcode_type op, input logic [3:0] rg,
                               input logic [31:0] v);
      req_item_type it;
      it.opcode      = op;
      it.reg_index   = rg;
      it.write_value = v;
      access_q.push_back(it);
      items_queued++;
   endtask

   // idle length for either side: mostly none or short, now and then long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // ---------------------------------------------------------------------------
   // driver: offers queued items, predicts each one as it is accepted
   // payload only moves when the current item is taken or nothing is offered
   // ---------------------------------------------------------------------------
   int send_idle;
   int send_quiet;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         send_idle  <= 0;
         send_quiet <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_rsp.push_back(apply_access(req_item));
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_idle != 0) begin
               req_valid <= 1'b0;
               send_idle <= send_idle - 1;
            end else if (access_q.size() != 0) begin
               req_item  <= access_q.pop_front();
               req_valid <= 1'b1;
               // quiet stretch: back-to-back items with no gaps
               if (send_quiet != 0) begin
                  send_quiet <= send_quiet - 1;
               end else begin
                  send_idle <= idle_length();
                  if ($urandom_range(0, 99) == 0) send_quiet <= $urandom_range(30, 100);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold, once, so the pipe backs up and req_stall has to rise
   int hold_left;
   logic hold_done;

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: takes results, checks each field against the oldest prediction,
   // and stalls at random independent of whether a result is present
   // ---------------------------------------------------------------------------
   int recv_idle;
   int recv_quiet;

   always @(posedge clock) begin : result_monitor
      rsp_item_type want;
      int           n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         recv_idle  <= 0;
         recv_quiet <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               $error("unexpected result item: read_data %h cur_mode %h",
                      rsp_item.read_data, rsp_item.cur_mode);
               fail_count++;
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_item.read_data !== want.read_data) begin
                  $error("read_data expected %h actual %h", want.read_data, rsp_item.read_data);
                  fail_count++;
               end
               if (rsp_item.cur_mode !== want.cur_mode) begin
                  $error("cur_mode expected %h actual %h", want.cur_mode, rsp_item.cur_mode);
                  fail_count++;
               end
               if (rsp_item.mode_has_saved !== want.mode_has_saved) begin
                  $error("mode_has_saved expected %b actual %b",
                         want.mode_has_saved, rsp_item.mode_has_saved);
                  fail_count++;
               end
               if (rsp_item.is_privileged !== want.is_privileged) begin
                  $error("is_privileged expected %b actual %b",
                         want.is_privileged, rsp_item.is_privileged);
                  fail_count++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
         end else if (recv_idle != 0) begin
            rsp_stall <= 1'b1;
            recv_idle <= recv_idle - 1;
         end else if (recv_quiet != 0) begin
            rsp_stall  <= 1'b0;
            recv_quiet <= recv_quiet - 1;
         end else begin
            n = idle_length();
            rsp_stall <= (n != 0);
            if (n != 0) recv_idle <= n - 1;
            else if ($urandom_range(0, 99) == 0) recv_quiet <= $urandom_range(30, 100);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int          k;
      int          r;
      opcode_type  op;
      logic [3:0]  rg;
      logic [31:0] v;

      cpsr       = RESET_STATUS;
      spsr       = '{default: '0};
      reg_copies = '{default: '0};

      // directed: starts in supervisor mode straight out of reset
      queue_access(OP_WRITE,        4'd0,  32'hFFFF_FFFF);
      queue_access(OP_WRITE,        4'd15, 32'h0000_0000);
      queue_access(OP_WRITE,        4'd13, 32'hA5A5_5A5A);   // svc r13
      queue_access(OP_READ,         4'd13, 32'h0);
      queue_access(OP_SAVED_WRITE,  4'd0,  32'hFFFF_FFFF);   // svc saved word
      queue_access(OP_SAVED_READ,   4'd0,  32'h0);
      queue_access(OP_STATUS_WRITE, 4'd0,  {27'h7FF_FFFF, M_FIQ});
      queue_access(OP_WRITE,        4'd8,  32'h1234_5678);   // fiq copy of r8
      queue_access(OP_USER_WRITE,   4'd12, 32'hCAFE_F00D);   // user copy of r12 from fiq
      queue_access(OP_READ,         4'd12, 32'h0);
      queue_access(OP_USER_READ,    4'd12, 32'h0);
      queue_access(OP_USER_READ,    4'd13, 32'h0);
      queue_access(OP_STATUS_READ,  4'd0,  32'h0);
      queue_access(OP_STATUS_WRITE, 4'd0,  {27'h0, M_SYS});
      queue_access(OP_SAVED_READ,   4'd0,  32'h0);           // system reads the status word
      queue_access(OP_SAVED_WRITE,  4'd0,  32'hDEAD_BEEF);   // dropped in system mode
      queue_access(OP_READ,         4'd8,  32'h0);
      queue_access(OP_STATUS_WRITE, 4'd0,  32'h0000_0005);   // invalid mode
      queue_access(OP_READ,         4'd14, 32'h0);           // no r14 in an invalid mode
      queue_access(OP_WRITE,        4'd13, 32'h5555_AAAA);   // dropped
      queue_access(OP_WRITE,        4'd9,  32'h0F0F_F0F0);   // falls to the user copy
      queue_access(OP_SAVED_READ,   4'd0,  32'h0);
      queue_access(OP_SAVED_WRITE,  4'd0,  32'h8000_0001);   // dropped
      queue_access(OP_STATUS_WRITE, 4'd0,  {27'h0, M_SVC});  // privileged mask from invalid

      // random accesses; mode switches keep the machine moving through every mode,
      // and user mode comes last since nothing can leave it without a reset
      for (k = 0; k < ITEM_COUNT; k++) begin
         r  = $urandom_range(0, 99);
         rg = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(8, 14))
                                          : 4'($urandom_range(0, 15));
         v  = $urandom();
         if (k == USER_ENTRY) begin
            op     = OP_STATUS_WRITE;
            v[4:0] = M_USR;
         end else begin
            if (r < 22)      op = OP_READ;
            else if (r < 32) op = OP_USER_READ;
            else if (r < 52) op = OP_WRITE;
            else if (r < 60) op = OP_USER_WRITE;
            else if (r < 67) op = OP_STATUS_READ;
            else if (r < 79) op = OP_STATUS_WRITE;
            else if (r < 88) op = OP_SAVED_READ;
            else             op = OP_SAVED_WRITE;
            if (op == OP_STATUS_WRITE && k < USER_ENTRY) begin
               case ($urandom_range(0, 7))
                  0:       v[4:0] = M_FIQ;
                  1:       v[4:0] = M_IRQ;
                  2:       v[4:0] = M_SVC;
                  3:       v[4:0] = M_ABT;
                  4:       v[4:0] = M_UND;
                  5:       v[4:0] = M_SYS;
                  default: begin
                     // any other code, mostly invalid ones; user mode held back
                     v[4:0] = 5'($urandom_range(0, 31));
                     if (v[4:0] == M_USR) v[4:0] = M_SYS;
                  end
               endcase
            end
         end
         queue_access(op, rg, v);
      end

      @(negedge reset);
      while (items_accepted != items_queued || predicted_rsp.size() != 0) @(posedge clock);
      // let any stray extra result show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/brf_pkg.sv
rtl/brf_regs.sv
rtl/brf_psr.sv
rtl/banked_register_file_modes.sv
sim/banked_register_file_modes_tb.sv
